/* rtl/core/murmur2_hash32_stream_top_defines.svh */
// assertion macros for the murmur2 hash stream block
`ifndef MURMUR2_HASH32_STREAM_TOP_DEFINES_SVH
`define MURMUR2_HASH32_STREAM_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MH2_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mh2 check failed");

// next-cycle implication, checked out of reset
`define MH2_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mh2 check failed");

`endif

/* rtl/core/mh2_pkg.sv */
// shared constants and types for the murmur2 hash stream block
package mh2_pkg;

  localparam logic [31:0] MIX_MUL = 32'h5bd1e995;

  localparam int unsigned SHIFT_K  = 24;
  localparam int unsigned SHIFT_A1 = 13;
  localparam int unsigned SHIFT_A2 = 15;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_FULL = 2'd1;
  localparam logic [1:0] KIND_TAIL = 2'd2;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  kind;
    logic        first;
    logic        last;
    logic [31:0] len;
  } op_t;

endpackage

/* rtl/core/murmur2_hash32_stream_top.sv */
// murmur2 32-bit stream hash, top level
// an item enters a two-deep queue and is mixed by one shared multiplier
// steps from idle: full word K1, K2, HM; tail TM; empty none; a last item adds AV, OUT
// the result is registered in OUT, later while an earlier result waits
// reset (rst, synchronous) empties the queue and clears seed and running hash
`include "murmur2_hash32_stream_top_defines.svh"

module murmur2_hash32_stream_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        first,
  input  logic        last,
  input  logic [31:0] total_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value
);

  logic         q_valid;
  logic         q_ready;
  mh2_pkg::op_t q_item;
  logic [31:0]  seed_r;
  logic         pop_full;

  assign cfg_ready = 1'b1;
  assign pop_full  = q_valid && q_ready && (q_item.kind == mh2_pkg::KIND_FULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_r <= 32'h0;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= seed;
    end
  end

  mh2_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_word    (data_word),
    .valid_bytes  (valid_bytes),
    .first        (first),
    .last         (last),
    .total_length (total_length),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item)
  );

  mh2_back u_back (
    .clk        (clk),
    .rst        (rst),
    .seed       (seed_r),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

  `MH2_ASSERT_IMPLIES(a_full_has_data, !in_ready, q_valid)
  `MH2_ASSERT_IMPLIES(a_result_after_work, $rose(out_valid), !$past(q_ready))
  `MH2_ASSERT_NEXT(a_pop_full_word_busy, pop_full, !q_ready)

endmodule

/* rtl/core/mh2_front.sv */
// input side: classifies and masks each item and queues it for the mixer
module mh2_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [31:0]      data_word,
  input  logic [2:0]       valid_bytes,
  input  logic             first,
  input  logic             last,
  input  logic [31:0]      total_length,
  output logic             q_valid,
  input  logic             q_ready,
  output mh2_pkg::op_t     q_item
);

  mh2_pkg::op_t cls;
  mh2_pkg::op_t q [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  always_comb begin
    cls.first = first;
    cls.last  = last;
    cls.len   = total_length;
    unique case (valid_bytes)
      3'd0: begin
        cls.kind = mh2_pkg::KIND_NONE;
        cls.word = 32'h0;
      end
      3'd1: begin
        cls.kind = mh2_pkg::KIND_TAIL;
        cls.word = {24'h0, data_word[7:0]};
      end
      3'd2: begin
        cls.kind = mh2_pkg::KIND_TAIL;
        cls.word = {16'h0, data_word[15:0]};
      end
      3'd3: begin
        cls.kind = mh2_pkg::KIND_TAIL;
        cls.word = {8'h0, data_word[23:0]};
      end
      default: begin
        cls.kind = mh2_pkg::KIND_FULL;
        cls.word = data_word;
      end
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = q[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/mh2_back.sv */
// mixing sequencer: one shared multiplier steps each queued item through the hash
module mh2_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      seed,
  input  logic             q_valid,
  output logic             q_ready,
  input  mh2_pkg::op_t     q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      hash_value
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_K1   = 3'd1;
  localparam logic [2:0] S_K2   = 3'd2;
  localparam logic [2:0] S_HM   = 3'd3;
  localparam logic [2:0] S_TM   = 3'd4;
  localparam logic [2:0] S_AV   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]  state;
  logic [31:0] h;
  logic [31:0] k;
  logic        last_r;
  logic [31:0] base;
  logic [31:0] mul_a;
  logic [31:0] prod;
  logic        slot_free;

  assign q_ready   = (state == S_IDLE);
  assign base      = q_item.first ? (seed ^ q_item.len) : h;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    unique case (state)
      S_HM, S_TM: mul_a = h;
      S_AV:       mul_a = h ^ (h >> mh2_pkg::SHIFT_A1);
      default:    mul_a = k;
    endcase
  end

  assign prod = mul_a * mh2_pkg::MIX_MUL;

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          last_r <= q_item.last;
          k      <= q_item.word;
        end
      end
      S_K1: k <= prod ^ (prod >> mh2_pkg::SHIFT_K);
      S_K2: k <= prod;
      S_AV: k <= prod;
      default: begin
      end
    endcase
    if (state == S_OUT && slot_free) begin
      hash_value <= k ^ (k >> mh2_pkg::SHIFT_A2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      h         <= 32'h0;
    end else begin
      if (state == S_OUT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.kind == mh2_pkg::KIND_TAIL) begin
              h <= base ^ q_item.word;
            end else begin
              h <= base;
            end
            priority if (q_item.kind == mh2_pkg::KIND_FULL) begin
              state <= S_K1;
            end else if (q_item.kind == mh2_pkg::KIND_TAIL) begin
              state <= S_TM;
            end else if (q_item.last) begin
              state <= S_AV;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_K1: state <= S_K2;
        S_K2: state <= S_HM;
        S_HM: begin
          h     <= prod ^ k;
          state <= last_r ? S_AV : S_IDLE;
        end
        S_TM: begin
          h     <= prod;
          state <= last_r ? S_AV : S_IDLE;
        end
        S_AV: state <= S_OUT;
        S_OUT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
